### sv/tcw_pkg.sv
package tcw_pkg;

   // Screen geometry defaults
   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;

   // Fixed field widths
   localparam int REQ_TYPE_W  = 2;
   localparam int BYTE_W      = 8;
   localparam int OUT_COL_W   = 7;
   localparam int OUT_ROW_W   = 5;
   localparam int OUT_OFS_W   = 11;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 4;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7F;

   // Blank light grey cell that the screen holds after reset
   localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0720;
   localparam logic [COLOR_W-1:0] FG_RESET   = 4'h7;
   localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUT_CHAR = 2'd0,
      REQ_SET_POS  = 2'd1,
      REQ_CLEAR    = 2'd2,
      REQ_READ     = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR = 1'b0,
      CSR_BG_COLOR = 1'b1
   } csr_index_type;

   // Decoded operation of the held request
   typedef enum logic [2:0] {
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_RETURN,
      OP_PRINT,
      OP_BAD_CHAR,
      OP_SET_POS,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic fill_rst;
      logic fill_clr;
      logic copy;
      logic blank;
      logic emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   scroll_need;
      logic   fill_last;
      logic   copy_done;
      logic   out_free;
   } status_type;

endpackage

### sv/tcw_if.sv
interface tcw_req_if import tcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BYTE_W-1:0]     char_code;
   logic [BYTE_W-1:0]     target_col;
   logic [BYTE_W-1:0]     target_row;

   modport source (output valid, req_type, char_code, target_col, target_row, input ready);
   modport sink   (input valid, req_type, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_COL_W-1:0] cursor_col;
   logic [OUT_ROW_W-1:0] cursor_row;
   logic [OUT_OFS_W-1:0] cursor_offset;
   logic [CELL_W-1:0]    cell_data;
   logic                 scrolled;
   logic                 ignored;

   modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_data,
                   scrolled, ignored, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_data,
                   scrolled, ignored, output ready);
endinterface

### sv/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence each request through the datapath
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_rst = 1'b1;
            if (sts.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.op == OP_CLEAR) begin
               state_in = ST_CLEAR;
            end else if (sts.scroll_need) begin
               state_in = ST_COPY;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.fill_clr = 1'b1;
            if (sts.fill_last) state_in = ST_DONE;
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_done) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank = 1'b1;
            if (sts.fill_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

### sv/tcw_dp.sv
module tcw_dp import tcw_pkg::*; #(
   parameter int COLS = COLS_DEFAULT,
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request payload
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [BYTE_W-1:0]     char_code,
   input  logic [BYTE_W-1:0]     target_col,
   input  logic [BYTE_W-1:0]     target_row,
   // result register
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [OUT_COL_W-1:0]  rsp_cursor_col,
   output logic [OUT_ROW_W-1:0]  rsp_cursor_row,
   output logic [OUT_OFS_W-1:0]  rsp_cursor_offset,
   output logic [CELL_W-1:0]     rsp_cell_data,
   output logic                  rsp_scrolled,
   output logic                  rsp_ignored,
   // control
   input  cmd_type               cmd,
   output status_type            sts
);

   localparam int NCELLS   = COLS * ROWS;
   localparam int AW       = $clog2(NCELLS);
   localparam int CW       = $clog2(COLS);
   localparam int RW       = $clog2(ROWS);
   localparam int COPY_END = NCELLS - COLS;

   localparam logic [AW-1:0]     COLS_A     = AW'(COLS);
   localparam logic [AW-1:0]     COPY_END_A = AW'(COPY_END);
   localparam logic [AW-1:0]     LAST_A     = AW'(NCELLS - 1);
   localparam logic [CW-1:0]     COL_LAST   = CW'(COLS - 1);
   localparam logic [RW-1:0]     ROW_LAST   = RW'(ROWS - 1);
   localparam logic [BYTE_W-1:0] COLS_B     = BYTE_W'(COLS);
   localparam logic [BYTE_W-1:0] ROWS_B     = BYTE_W'(ROWS);

   // Held request
   req_kind_type      kind_ff;
   logic [BYTE_W-1:0] ch_ff, tc_ff, tr_ff;

   // Cursor, colors and per-request flags
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [COLOR_W-1:0] fg_ff, fg_in, bg_ff, bg_in;
   logic               scrolled_ff, scrolled_in;
   logic               ignored_ff, ignored_in;

   // Sweep counter and copy pipeline
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          copy_pend_ff, copy_pend_in;
   logic [AW-1:0] copy_addr_ff;

   // Cell memory
   logic [CELL_W-1:0] mem_ff [0:NCELLS-1];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_OFS_W-1:0] rsp_ofs_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic                 rsp_scr_ff, rsp_ign_ff;

   op_type            op;
   logic              tgt_ok, col_last, row_last, col_zero;
   logic              use_tgt, use_bs, copy_issue;
   logic [BYTE_W-1:0] mrow, mcol;
   logic [AW-1:0]     cell_addr;
   logic [CELL_W-1:0] blank_cell, print_cell;

   // Decode the held request
   always_comb begin
      op = OP_BAD_CHAR;
      unique case (kind_ff)
         REQ_PUT_CHAR: begin
            if (ch_ff == CH_NEWLINE) begin
               op = OP_NEWLINE;
            end else if (ch_ff == CH_BACKSPACE) begin
               op = OP_BACKSPACE;
            end else if (ch_ff == CH_RETURN) begin
               op = OP_RETURN;
            end else if (ch_ff >= CH_PRINT_LO && ch_ff <= CH_PRINT_HI) begin
               op = OP_PRINT;
            end else begin
               op = OP_BAD_CHAR;
            end
         end
         REQ_SET_POS: op = OP_SET_POS;
         REQ_CLEAR:   op = OP_CLEAR;
         REQ_READ:    op = OP_READ;
         default:     op = OP_BAD_CHAR;
      endcase
   end

   assign tgt_ok   = (tc_ff < COLS_B) && (tr_ff < ROWS_B);
   assign col_last = (col_ff == COL_LAST);
   assign row_last = (row_ff == ROW_LAST);
   assign col_zero = (col_ff == '0);

   assign blank_cell = {bg_ff, fg_ff, CH_SPACE};
   assign print_cell = {bg_ff, fg_ff, ch_ff};

   // Shared cell address: row * COLS + col
   assign use_tgt   = cmd.exec && (op == OP_READ);
   assign use_bs    = cmd.exec && (op == OP_BACKSPACE);
   assign mrow      = use_tgt ? tr_ff : BYTE_W'(row_ff);
   assign mcol      = use_tgt ? tc_ff :
                      use_bs  ? BYTE_W'(col_ff - CW'(1)) : BYTE_W'(col_ff);
   assign cell_addr = AW'(mrow) * COLS_A + AW'(mcol);

   // Status to the controller
   always_comb begin
      sts.op          = op;
      sts.scroll_need = row_last && ((op == OP_NEWLINE) || (op == OP_PRINT && col_last));
      sts.fill_last   = (cnt_ff == LAST_A);
      sts.copy_done   = (cnt_ff == COPY_END_A);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection
   assign copy_issue = cmd.copy && (cnt_ff != COPY_END_A);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = RESET_CELL;
      if (cmd.fill_rst) begin
         mem_we = 1'b1;
      end else if (cmd.fill_clr || cmd.blank) begin
         mem_we    = 1'b1;
         mem_wdata = blank_cell;
      end else if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = rdata_ff;
      end else if (cmd.exec && op == OP_PRINT) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr;
         mem_wdata = print_cell;
      end else if (cmd.exec && op == OP_BACKSPACE && !col_zero) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr;
         mem_wdata = blank_cell;
      end
   end

   assign mem_re    = copy_issue || (use_tgt && tgt_ok);
   assign mem_raddr = copy_issue ? AW'(cnt_ff + COLS_A) : cell_addr;

   // Cell memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem_ff[mem_raddr];
   end

   // Sweep counter and copy pipeline
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.exec) begin
         cnt_in = '0;
      end else if (cmd.fill_rst || cmd.fill_clr || cmd.blank || copy_issue) begin
         cnt_in = cnt_ff + AW'(1);
      end
      copy_pend_in = copy_issue;
   end

   // Cursor and flag updates
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      scrolled_in = scrolled_ff;
      ignored_in  = ignored_ff;
      if (cmd.latch) begin
         scrolled_in = 1'b0;
         ignored_in  = 1'b0;
      end else if (cmd.exec) begin
         case (op)
            OP_NEWLINE: begin
               col_in      = '0;
               scrolled_in = row_last;
               if (!row_last) row_in = row_ff + RW'(1);
            end
            OP_BACKSPACE: begin
               if (!col_zero) col_in = col_ff - CW'(1);
            end
            OP_RETURN: begin
               col_in = '0;
            end
            OP_PRINT: begin
               if (col_last) begin
                  col_in      = '0;
                  scrolled_in = row_last;
                  if (!row_last) row_in = row_ff + RW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
            OP_SET_POS: begin
               if (tgt_ok) begin
                  col_in = CW'(tc_ff);
                  row_in = RW'(tr_ff);
               end else begin
                  ignored_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            OP_READ: begin
               if (!tgt_ok) ignored_in = 1'b1;
            end
            default: begin
               ignored_in = 1'b1;
            end
         endcase
      end
   end

   // Color registers
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FG_COLOR: fg_in = COLOR_W'(csr_wdata);
            CSR_BG_COLOR: bg_in = COLOR_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scrolled_ff  <= scrolled_in;
      ignored_ff   <= ignored_in;
      copy_addr_ff <= cnt_ff;
      if (cmd.latch) begin
         kind_ff <= req_kind_type'(req_type);
         ch_ff   <= char_code;
         tc_ff   <= target_col;
         tr_ff   <= target_row;
      end
      if (cmd.emit) begin
         rsp_col_ff  <= OUT_COL_W'(col_ff);
         rsp_row_ff  <= OUT_ROW_W'(row_ff);
         rsp_ofs_ff  <= OUT_OFS_W'(cell_addr);
         rsp_cell_ff <= (op == OP_READ && !ignored_ff) ? rdata_ff : '0;
         rsp_scr_ff  <= scrolled_ff;
         rsp_ign_ff  <= ignored_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_offset = rsp_ofs_ff;
   assign rsp_cell_data     = rsp_cell_ff;
   assign rsp_scrolled      = rsp_scr_ff;
   assign rsp_ignored       = rsp_ign_ff;

endmodule

### sv/text_console_char_writer_unit.sv
// Text console of COLS x ROWS 16-bit cells (attribute byte over character byte) that
// answers every request with exactly one result beat carrying the cursor after the
// request. Requests are taken one at a time. A clear and a put character that scrolls
// are paced by the single write port of the cell memory, which moves one cell per cycle
// (a scroll copies COLS*(ROWS-1) cells through the registered read port, then blanks
// the bottom row). After reset a sweep fills the screen with 0x0720 while no request
// is taken; color writes are taken at any time but should only be made while no
// request is in flight. A finished result waits in its own register, so the next
// request can enter while the previous result is still held.
module text_console_char_writer_unit import tcw_pkg::*; #(
   parameter int COLS = COLS_DEFAULT,
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_ch,
   tcw_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_ch.req_type),
      .char_code         (req_ch.char_code),
      .target_col        (req_ch.target_col),
      .target_row        (req_ch.target_row),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_cursor_col    (rsp_ch.cursor_col),
      .rsp_cursor_row    (rsp_ch.cursor_row),
      .rsp_cursor_offset (rsp_ch.cursor_offset),
      .rsp_cell_data     (rsp_ch.cell_data),
      .rsp_scrolled      (rsp_ch.scrolled),
      .rsp_ignored       (rsp_ch.ignored),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

### sv/tcw_checker.sv
module tcw_checker import tcw_pkg::*; #(
   parameter int COLS = COLS_DEFAULT,
   parameter int ROWS = ROWS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_COL_W-1:0] rsp_cursor_col,
   input logic [OUT_ROW_W-1:0] rsp_cursor_row,
   input logic [OUT_OFS_W-1:0] rsp_cursor_offset,
   input logic [CELL_W-1:0]    rsp_cell_data,
   input logic                 rsp_scrolled,
   input logic                 rsp_ignored
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_col)
         && $stable(rsp_cursor_row) && $stable(rsp_cursor_offset)
         && $stable(rsp_cell_data) && $stable(rsp_scrolled) && $stable(rsp_ignored))
      else $error("result beat changed while stalled");

   // Keep the cursor on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_cursor_col) < COLS) && (int'(rsp_cursor_row) < ROWS))
      else $error("cursor off screen");

   // A scroll leaves the cursor at the start of the bottom row, with no drop and no cell data
   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_col == '0
         && rsp_cursor_row == OUT_ROW_W'(ROWS - 1) && !rsp_ignored && rsp_cell_data == '0)
      else $error("scroll result inconsistent");

   // Cell data only comes with a read that was not dropped
   a_cell_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_data != '0 |-> !rsp_ignored && !rsp_scrolled)
      else $error("cell data on dropped or scrolling request");

   // Drop ready for the cycle after a request beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind text_console_char_writer_unit tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_cursor_col    (rsp_ch.cursor_col),
   .rsp_cursor_row    (rsp_ch.cursor_row),
   .rsp_cursor_offset (rsp_ch.cursor_offset),
   .rsp_cell_data     (rsp_ch.cell_data),
   .rsp_scrolled      (rsp_ch.scrolled),
   .rsp_ignored       (rsp_ch.ignored)
);

### tb/tb.sv
`timescale 1ns / 1ps

import tcw_pkg::*;

localparam int NCOLS  = COLS_DEFAULT;
localparam int NROWS  = ROWS_DEFAULT;
localparam int NCELLS = NCOLS * NROWS;

typedef struct packed {
   req_kind_type         kind;
   logic [BYTE_W-1:0]    code;
   logic [BYTE_W-1:0]    tcol;
   logic [BYTE_W-1:0]    trow;
} console_req_type;

typedef struct packed {
   logic [OUT_COL_W-1:0] col;
   logic [OUT_ROW_W-1:0] row;
   logic [OUT_OFS_W-1:0] offset;
   logic [CELL_W-1:0]    cell_word;
   logic                 scrolled;
   logic                 ignored;
} cursor_state_type;

// Mirror of the screen and cursor; predicts the result beat of every request
class screen_mirror_type;
   logic [CELL_W-1:0]  cells [NCELLS];
   int                 col;
   int                 row;
   logic [COLOR_W-1:0] fg;
   logic [COLOR_W-1:0] bg;
   cursor_state_type   pending_cursor [$];
   int                 mismatches;
   int                 requests;
   int                 scrolls;
   int                 cell_reads;
   int                 dropped;
   int                 beats_checked;

   function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      col = 0;
      row = 0;
      fg = FG_RESET;
      bg = BG_RESET;
      mismatches = 0;
      requests = 0;
      scrolls = 0;
      cell_reads = 0;
      dropped = 0;
      beats_checked = 0;
   endfunction

   function void set_color(csr_index_type idx, logic [COLOR_W-1:0] v);
      if (idx == CSR_FG_COLOR) begin
         fg = v;
      end else begin
         bg = v;
      end
   endfunction

   function logic [CELL_W-1:0] tinted(logic [BYTE_W-1:0] ch);
      return {bg, fg, ch};
   endfunction

   // Step down one row; on the last row shift everything up and blank the bottom
   function logic advance_row();
      row++;
      if (row < NROWS) return 1'b0;
      for (int i = 0; i < NCELLS - NCOLS; i++) cells[i] = cells[i + NCOLS];
      for (int i = NCELLS - NCOLS; i < NCELLS; i++) cells[i] = tinted(CH_SPACE);
      row = NROWS - 1;
      scrolls++;
      return 1'b1;
   endfunction

   // Note an accepted request beat and queue the cursor it leaves behind
   function void apply_request(console_req_type r);
      cursor_state_type want;
      logic             on_screen;
      want = '0;
      on_screen = (r.tcol < NCOLS) && (r.trow < NROWS);
      requests++;
      case (r.kind)
         REQ_PUT_CHAR: begin
            if (r.code == CH_NEWLINE) begin
               col = 0;
               want.scrolled = advance_row();
            end else if (r.code == CH_BACKSPACE) begin
               if (col > 0) begin
                  col--;
                  cells[row * NCOLS + col] = tinted(CH_SPACE);
               end
            end else if (r.code == CH_RETURN) begin
               col = 0;
            end else if (r.code >= CH_PRINT_LO && r.code <= CH_PRINT_HI) begin
               cells[row * NCOLS + col] = tinted(r.code);
               col++;
               if (col >= NCOLS) begin
                  col = 0;
                  want.scrolled = advance_row();
               end
            end else begin
               want.ignored = 1'b1;
            end
         end
         REQ_SET_POS: begin
            if (on_screen) begin
               col = int'(r.tcol);
               row = int'(r.trow);
            end else begin
               want.ignored = 1'b1;
            end
         end
         REQ_CLEAR: begin
            foreach (cells[i]) cells[i] = tinted(CH_SPACE);
            col = 0;
            row = 0;
         end
         default: begin
            if (on_screen) begin
               want.cell_word = cells[int'(r.trow) * NCOLS + int'(r.tcol)];
               cell_reads++;
            end else begin
               want.ignored = 1'b1;
            end
         end
      endcase
      if (want.ignored) dropped++;
      want.col = OUT_COL_W'(col);
      want.row = OUT_ROW_W'(row);
      want.offset = OUT_OFS_W'(row * NCOLS + col);
      pending_cursor.push_back(want);
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task check_field(string name, int beat, logic [CELL_W-1:0] got,
                    logic [CELL_W-1:0] want);
      if (got !== want)
         report($sformatf("beat %0d %s got 0x%0h want 0x%0h", beat, name, got, want));
   endtask

   // Compare an accepted result beat against the oldest queued cursor
   task compare_cursor(cursor_state_type got);
      cursor_state_type want;
      if (pending_cursor.size() == 0) begin
         report("result beat with no request outstanding");
      end else begin
         want = pending_cursor.pop_front();
         check_field("cursor_col", beats_checked, CELL_W'(got.col), CELL_W'(want.col));
         check_field("cursor_row", beats_checked, CELL_W'(got.row), CELL_W'(want.row));
         check_field("cursor_offset", beats_checked, CELL_W'(got.offset),
                     CELL_W'(want.offset));
         check_field("cell_data", beats_checked, got.cell_word, want.cell_word);
         check_field("scrolled", beats_checked, CELL_W'(got.scrolled),
                     CELL_W'(want.scrolled));
         check_field("ignored", beats_checked, CELL_W'(got.ignored),
                     CELL_W'(want.ignored));
      end
      beats_checked++;
   endtask
endclass

module tb;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int MAX_GAP         = 19;
   localparam int QUIET_LIMIT     = 20000;
   localparam int TAIL_CYCLES     = 50;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    no_idle = 1'b0;
   int                    color_writes = 0;
   screen_mirror_type     mirror = new();

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_char_writer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic console_req_type make_req(req_kind_type kind, logic [7:0] code,
                                                logic [7:0] tcol, logic [7:0] trow);
      console_req_type r;
      r.kind = kind;
      r.code = code;
      r.tcol = tcol;
      r.trow = trow;
      return r;
   endfunction

   // Mostly text with line control, some cursor moves and reads, rare clears
   function automatic console_req_type random_request();
      console_req_type r;
      int              pick;
      int              sub;
      r = make_req(REQ_PUT_CHAR, BYTE_W'($urandom_range(0, 255)),
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 99);
      if (pick < 55) begin
         if (sub < 72) r.code = BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
         else if (sub < 80) r.code = CH_NEWLINE;
         else if (sub < 84) r.code = CH_RETURN;
         else if (sub < 91) r.code = CH_BACKSPACE;
      end else if (pick < 67) begin
         r.kind = REQ_SET_POS;
         if (sub < 80) begin
            r.tcol = BYTE_W'($urandom_range(0, NCOLS - 1));
            r.trow = BYTE_W'($urandom_range(0, NROWS - 1));
         end
      end else if (pick < 97) begin
         r.kind = REQ_READ;
         if (sub < 85) begin
            r.tcol = BYTE_W'($urandom_range(0, NCOLS - 1));
            r.trow = (sub < 45) ? BYTE_W'(mirror.row) : BYTE_W'($urandom_range(0, NROWS - 1));
         end
      end else begin
         r.kind = REQ_CLEAR;
      end
      return r;
   endfunction

   // Present one request beat after a random gap (none under no_idle) and hold it until taken
   task automatic drive_request(input console_req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.req_type   = r.kind;
      req_ch.char_code  = r.code;
      req_ch.target_col = r.tcol;
      req_ch.target_row = r.trow;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      mirror.apply_request(r);
   endtask

   // Drop valid and hold until every outstanding result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (mirror.pending_cursor.size() != 0) @(negedge clock);
   endtask

   task automatic write_color(input csr_index_type idx, input logic [COLOR_W-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      mirror.set_color(idx, v);
      color_writes++;
   endtask

   // Result side: stall at random (not under no_idle), then take and check one beat
   initial begin : result_side
      cursor_state_type got;
      rsp_ch.ready = 1'b0;
      forever begin
         int stall;
         @(negedge clock);
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (reset || rsp_ch.valid !== 1'b1);
         got.col       = rsp_ch.cursor_col;
         got.row       = rsp_ch.cursor_row;
         got.offset    = rsp_ch.cursor_offset;
         got.cell_word = rsp_ch.cell_data;
         got.scrolled  = rsp_ch.scrolled;
         got.ignored   = rsp_ch.ignored;
         mirror.compare_cursor(got);
      end
   end

   // Abort when no beat moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("[text_console_char_writer_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [COLOR_W-1:0] fg_plan [PHASES];
      logic [COLOR_W-1:0] bg_plan [PHASES];
      fg_plan = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0};
      bg_plan = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd0};
      for (int i = PHASES - 2; i < PHASES; i++) begin
         fg_plan[i] = COLOR_W'($urandom_range(0, 15));
         bg_plan[i] = COLOR_W'($urandom_range(0, 15));
      end
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_FG_COLOR;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_PUT_CHAR;
      req_ch.char_code  = '0;
      req_ch.target_col = '0;
      req_ch.target_row = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: corners of reads and moves, every byte class, wrap and scroll
      drive_request(make_req(REQ_READ, 8'h00, 8'd0, 8'd0));
      drive_request(make_req(REQ_READ, 8'h00, 8'd79, 8'd24));
      drive_request(make_req(REQ_READ, 8'h00, 8'd80, 8'd0));
      drive_request(make_req(REQ_READ, 8'h00, 8'd0, 8'd25));
      drive_request(make_req(REQ_READ, 8'h00, 8'd255, 8'd255));
      drive_request(make_req(REQ_PUT_CHAR, 8'h00, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, 8'hFF, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, 8'h80, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, 8'h1F, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_BACKSPACE, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_SPACE, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_PRINT_HI, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_BACKSPACE, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_RETURN, 8'd0, 8'd0));
      drive_request(make_req(REQ_SET_POS, 8'h00, 8'd79, 8'd23));
      drive_request(make_req(REQ_PUT_CHAR, 8'h41, 8'd0, 8'd0));
      drive_request(make_req(REQ_SET_POS, 8'h00, 8'd80, 8'd24));
      drive_request(make_req(REQ_SET_POS, 8'h00, 8'd79, 8'd25));
      drive_request(make_req(REQ_SET_POS, 8'h00, 8'd255, 8'd0));
      drive_request(make_req(REQ_SET_POS, 8'h00, 8'd79, 8'd24));
      drive_request(make_req(REQ_PUT_CHAR, 8'h5A, 8'd0, 8'd0));
      drive_request(make_req(REQ_PUT_CHAR, CH_NEWLINE, 8'd0, 8'd0));
      drive_request(make_req(REQ_READ, 8'h00, 8'd79, 8'd21));
      drive_request(make_req(REQ_CLEAR, 8'h00, 8'd0, 8'd0));
      drive_request(make_req(REQ_READ, 8'h00, 8'd79, 8'd24));
      wait_idle();

      // Random phases, each under its own colors; every third one without idling
      for (int p = 0; p < PHASES; p++) begin
         write_color(CSR_FG_COLOR, fg_plan[p]);
         write_color(CSR_BG_COLOR, bg_plan[p]);
         no_idle = (p % 3 == 2);
         repeat (ITEMS_PER_PHASE) drive_request(random_request());
         wait_idle();
      end
      no_idle = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d requests under %0d color writes: %0d scrolls, %0d cell reads",
               mirror.requests, color_writes, mirror.scrolls, mirror.cell_reads);
      $display("checked %0d result beats, %0d dropped, %0d mismatches",
               mirror.beats_checked, mirror.dropped, mirror.mismatches);
      if (mirror.mismatches == 0 && mirror.pending_cursor.size() == 0) begin
         $display("[text_console_char_writer_unit] OK");
      end else begin
         $display("[text_console_char_writer_unit] ERROR");
      end
      $finish;
   end

endmodule
